// ----- hw/rtl/sct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, constants and helpers of the sparse census transform.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_RADIUS_DEF  = 7;
    localparam int MAX_SAMPLES_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam int PIX_W    = 8;
    localparam int DESC_W   = 16;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 11;
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 64;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_RADIUS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_FIRST  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_SECOND = 3'd5;

    typedef struct packed {
        logic [11:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  window_radius;
        logic [4:0]  sample_count;
        logic [63:0] pattern_first_half;
        logic [63:0] pattern_second_half;
    } cfg_t;

    // per-item control travelling from front to back
    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             frame_last;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

    // signed 4-bit offset clamped to [-rad, rad]
    function automatic logic signed [4:0] clamp_offset(input logic [3:0] nib,
                                                       input logic [2:0] rad);
        logic signed [4:0] v;
        logic signed [4:0] r;
        v = {nib[3], nib};
        r = $signed({2'b00, rad});
        if (v > r)
        begin
            v = r;
        end
        if (v < -r)
        begin
            v = -r;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/sct_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_ifs
// Valid/ready channel interfaces: pixel input, descriptor output, reg writes.
// ----------------------------------------------------------------------------
interface sct_pixel_if;
    import sct_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface sct_desc_if;
    import sct_pkg::*;
    logic              valid;
    logic              ready;
    logic [DESC_W-1:0] descriptor;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
    logic              frame_last;
    modport source (output valid, output descriptor, output center_row,
                    output center_col, output frame_last, input ready);
    modport sink (input valid, input descriptor, input center_row,
                  input center_col, input frame_last, output ready);
endinterface

interface sct_cfg_if;
    import sct_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [REG_DATA_W-1:0] reg_data;
    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ----- hw/rtl/sct_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sct_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module sct_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [LW-1:0]    level_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> level_reg != LW'(DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("queue underflow");

endmodule

// ----- hw/rtl/sct_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_front
// Raster counters, line store and column fetch; classifies each pixel item.
// ----------------------------------------------------------------------------
module sct_front #(
    parameter int MAX_WIDTH   = sct_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS  = sct_pkg::MAX_RADIUS_DEF,
    parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sct_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sct_pkg::PIX_W-1:0]            pixel_value,
    input  logic                                 frame_start,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_level,
    output logic                                 push,
    output logic [(2*MAX_RADIUS+1)*sct_pkg::PIX_W-1:0] col_data,
    output sct_pkg::ctl_t                        ctl
);
    import sct_pkg::*;

    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int SW = $clog2(LINE_ROWS);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SW-1:0]    slot_reg, slot_next;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [SW-1:0]    s1_slot_reg;
    ctl_t             s1_ctl_reg;

    logic [13:0]      w_raw, w_clamp;
    logic [WW-1:0]    w_eff;
    logic [12:0]      h_eff;
    logic [2:0]       rad;
    logic             accept;

    logic [CW-1:0]    c_a, c_b;
    logic [ROW_W-1:0] r_a, r_c;
    logic [SW-1:0]    s_a, s_b, s_c;
    logic [12:0]      r_b;
    logic [WW-1:0]    c_n;
    logic [12:0]      r_n;
    ctl_t             ctl_now;
    logic [3:0]       two_rad;

    logic [PIX_W-1:0] ram_q [LINE_ROWS];

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(LINE_ROWS - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb
    begin
        w_raw   = {2'b00, cfg.image_width};
        w_clamp = (w_raw == '0) ? 14'd1 :
                  (w_raw > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : w_raw;
        w_eff   = w_clamp[WW-1:0];
        h_eff   = (cfg.image_height == '0) ? 13'd1 :
                  (cfg.image_height > 13'd4096) ? 13'd4096 : cfg.image_height;
        rad     = (cfg.window_radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : cfg.window_radius;
        two_rad = {rad, 1'b0};
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = ({1'b0, q_level} + (LW+1)'(s1_valid_reg)) < (LW+1)'(QUEUE_DEPTH);

    // position of this pixel, then position of the next one
    always_comb
    begin
        c_a = frame_start ? '0 : col_reg;
        r_a = frame_start ? '0 : row_reg;
        s_a = frame_start ? '0 : slot_reg;
        if ({1'b0, c_a} >= w_eff)
        begin
            c_b = '0;
            r_b = {1'b0, r_a} + 13'd1;
            s_b = slot_inc(s_a);
        end
        else
        begin
            c_b = c_a;
            r_b = {1'b0, r_a};
            s_b = s_a;
        end
        if (r_b >= h_eff)
        begin
            r_c = '0;
            s_c = '0;
        end
        else
        begin
            r_c = r_b[ROW_W-1:0];
            s_c = s_b;
        end

        ctl_now.emit       = (r_c >= ROW_W'(two_rad)) && (c_b >= CW'(two_rad));
        ctl_now.center_row = r_c - ROW_W'(rad);
        ctl_now.center_col = COL_W'(c_b - CW'(rad));
        ctl_now.frame_last = ({1'b0, r_c} == h_eff - 13'd1) && ({1'b0, c_b} == w_eff - 1'b1);

        c_n       = {1'b0, c_b} + 1'b1;
        r_n       = {1'b0, r_c} + 13'd1;
        col_next  = c_n[CW-1:0];
        row_next  = r_c;
        slot_next = s_c;
        if (c_n >= w_eff)
        begin
            col_next = '0;
            if (r_n >= h_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = r_n[ROW_W-1:0];
                slot_next = slot_inc(s_c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel_value;
            s1_slot_reg <= s_c;
            s1_ctl_reg  <= ctl_now;
        end
    end

    // one line RAM per row slot; all read at the current column
    for (genvar i = 0; i < LINE_ROWS; i++)
    begin : g_line
        sct_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (accept && (s_c == SW'(i))),
            .waddr (c_b),
            .wdata (pixel_value),
            .re    (accept),
            .raddr (c_b),
            .rdata (ram_q[i])
        );
    end

    // column entry k holds row r-k; entry 0 is the new pixel itself
    always_comb
    begin
        logic [SW-1:0] idx;
        idx = '0;
        col_data[PIX_W-1:0] = s1_pix_reg;
        for (int k = 1; k < LINE_ROWS; k++)
        begin
            if (s1_slot_reg >= SW'(k))
            begin
                idx = s1_slot_reg - SW'(k);
            end
            else
            begin
                idx = s1_slot_reg + SW'(LINE_ROWS - k);
            end
            col_data[k*PIX_W +: PIX_W] = ram_q[idx];
        end
    end

    assign push = s1_valid_reg;
    assign ctl  = s1_ctl_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SW'(LINE_ROWS - 1))
        else $error("row slot out of range");

    a_row_slot_sync: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_start |=> slot_reg == '0 || row_reg != '0)
        else $error("row slot lost sync with row counter");

endmodule

// ----- hw/rtl/sct_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_back
// Sliding pixel window, sample compare and registered descriptor output.
// ----------------------------------------------------------------------------
module sct_back #(
    parameter int MAX_RADIUS  = sct_pkg::MAX_RADIUS_DEF,
    parameter int MAX_SAMPLES = sct_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  sct_pkg::cfg_t                               cfg,
    input  logic                                        q_valid,
    output logic                                        pop,
    input  logic [(2*MAX_RADIUS+1)*sct_pkg::PIX_W-1:0]  col_data,
    input  sct_pkg::ctl_t                               ctl,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [sct_pkg::DESC_W-1:0]                  descriptor,
    output logic [sct_pkg::ROW_W-1:0]                   center_row,
    output logic [sct_pkg::COL_W-1:0]                   center_col,
    output logic                                        frame_last
);
    import sct_pkg::*;

    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int SW = $clog2(LINE_ROWS);

    // win_reg[k][j]: row r-k, column c-j of the latest item
    logic [PIX_W-1:0]  win_reg [LINE_ROWS][LINE_ROWS];
    logic              a_valid_reg;
    ctl_t              a_ctl_reg;
    logic              o_valid_reg;
    logic [DESC_W-1:0] o_desc_reg;
    logic [ROW_W-1:0]  o_row_reg;
    logic [COL_W-1:0]  o_col_reg;
    logic              o_last_reg;

    logic              load_out;
    logic              a_free;
    logic [2:0]        rad;
    logic [4:0]        cnt;
    logic [DESC_W-1:0] desc_now;

    assign rad = (cfg.window_radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : cfg.window_radius;
    assign cnt = (cfg.sample_count > 5'(MAX_SAMPLES)) ? 5'(MAX_SAMPLES) : cfg.sample_count;

    assign load_out = a_valid_reg && a_ctl_reg.emit && (!o_valid_reg || out_ready);
    assign a_free   = !a_valid_reg || !a_ctl_reg.emit || load_out;
    assign pop      = q_valid && a_free;

    always_comb
    begin
        logic [7:0]        pat;
        logic signed [4:0] dy, dx;
        logic signed [4:0] kr, jc;
        logic [PIX_W-1:0]  center;
        logic [PIX_W-1:0]  samp;
        pat      = '0;
        dy       = '0;
        dx       = '0;
        kr       = '0;
        jc       = '0;
        samp     = '0;
        center   = win_reg[SW'(rad)][SW'(rad)];
        desc_now = '0;
        for (int s = 0; s < MAX_SAMPLES; s++)
        begin
            if (s < 8)
            begin
                pat = cfg.pattern_first_half[8*s +: 8];
            end
            else
            begin
                pat = cfg.pattern_second_half[8*(s-8) +: 8];
            end
            dy   = clamp_offset(pat[7:4], rad);
            dx   = clamp_offset(pat[3:0], rad);
            kr   = $signed({2'b00, rad}) - dy;
            jc   = $signed({2'b00, rad}) - dx;
            samp = win_reg[kr[SW-1:0]][jc[SW-1:0]];
            desc_now[s] = (5'(s) < cnt) && (samp >= center);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_ctl_reg <= ctl;
            for (int k = 0; k < LINE_ROWS; k++)
            begin
                win_reg[k][0] <= col_data[k*PIX_W +: PIX_W];
                for (int j = 1; j < LINE_ROWS; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j-1];
                end
            end
        end
        if (load_out)
        begin
            o_desc_reg <= desc_now;
            o_row_reg  <= a_ctl_reg.center_row;
            o_col_reg  <= a_ctl_reg.center_col;
            o_last_reg <= a_ctl_reg.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= pop;
            end
            if (load_out)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = o_valid_reg;
    assign descriptor = o_desc_reg;
    assign center_row = o_row_reg;
    assign center_col = o_col_reg;
    assign frame_last = o_last_reg;

    a_no_window_shift_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_ctl_reg.emit && o_valid_reg && !out_ready |-> !pop)
        else $error("window shifted under a held item");

    a_unused_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (desc_now >> cnt) == '0)
        else $error("descriptor bit beyond sample count");

endmodule

// ----- hw/rtl/sparse_census_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_census_transform
// Sparse census transform over a raster pixel stream, with register port.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per cycle while the queue has room and the output
//   is not stalled; each pixel does one line RAM write and one column read.
// Path: an accepted pixel passes the line RAM read register, the queue, the
//   window/compare stage and the output register; stalls can hold it between.
// Reset: counters, queue and handshakes clear; line RAMs and window are not
//   cleared and need no clearing pass. Registers return to their defaults.
module sparse_census_transform #(
    parameter int MAX_WIDTH   = sct_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS  = sct_pkg::MAX_RADIUS_DEF,
    parameter int MAX_SAMPLES = sct_pkg::MAX_SAMPLES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    sct_pixel_if.sink       pixel_in,
    sct_desc_if.source      desc_out,
    sct_cfg_if.sink         cfg_wr
);
    import sct_pkg::*;

    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int COLUMN_W  = LINE_ROWS * PIX_W;
    localparam int REC_W     = COLUMN_W + CTL_W;
    localparam int LW        = $clog2(QUEUE_DEPTH + 1);

    cfg_t                cfg_reg;
    logic                push, pop, q_valid;
    logic [LW-1:0]       q_level;
    logic [COLUMN_W-1:0] f_col, b_col;
    ctl_t                f_ctl, b_ctl;
    logic [REC_W-1:0]    q_rdata;

    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width         <= 12'd640;
            cfg_reg.image_height        <= 13'd480;
            cfg_reg.window_radius       <= 3'd2;
            cfg_reg.sample_count        <= 5'd16;
            cfg_reg.pattern_first_half  <= '0;
            cfg_reg.pattern_second_half <= '0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.reg_index)
                REG_IMAGE_WIDTH:    cfg_reg.image_width         <= cfg_wr.reg_data[11:0];
                REG_IMAGE_HEIGHT:   cfg_reg.image_height        <= cfg_wr.reg_data[12:0];
                REG_WINDOW_RADIUS:  cfg_reg.window_radius       <= cfg_wr.reg_data[2:0];
                REG_SAMPLE_COUNT:   cfg_reg.sample_count        <= cfg_wr.reg_data[4:0];
                REG_PATTERN_FIRST:  cfg_reg.pattern_first_half  <= cfg_wr.reg_data;
                REG_PATTERN_SECOND: cfg_reg.pattern_second_half <= cfg_wr.reg_data;
                default:            ;
            endcase
        end
    end

    sct_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_RADIUS  (MAX_RADIUS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (pixel_in.valid),
        .in_ready    (pixel_in.ready),
        .pixel_value (pixel_in.pixel_value),
        .frame_start (pixel_in.frame_start),
        .q_level     (q_level),
        .push        (push),
        .col_data    (f_col),
        .ctl         (f_ctl)
    );

    sct_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     ({f_ctl, f_col}),
        .pop       (pop),
        .rdata     (q_rdata),
        .not_empty (q_valid),
        .level     (q_level)
    );

    assign b_col = q_rdata[COLUMN_W-1:0];
    assign b_ctl = q_rdata[REC_W-1:COLUMN_W];

    sct_back #(
        .MAX_RADIUS  (MAX_RADIUS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .pop        (pop),
        .col_data   (b_col),
        .ctl        (b_ctl),
        .out_valid  (desc_out.valid),
        .out_ready  (desc_out.ready),
        .descriptor (desc_out.descriptor),
        .center_row (desc_out.center_row),
        .center_col (desc_out.center_col),
        .frame_last (desc_out.frame_last)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sparse_census_transform. A local predictor tracks
// the line store, raster counters and registers, and queues the descriptor
// each accepted pixel should give. Output items are checked field by field
// under random idle bursts on both channels, a long output hold and a drain
// pause, across several geometries, radii, sample counts and patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import sct_pkg::*;

    localparam int LINE_ROWS   = 2 * MAX_RADIUS_DEF + 1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        logic [DESC_W-1:0] descriptor;
        logic [ROW_W-1:0]  center_row;
        logic [COL_W-1:0]  center_col;
        logic              frame_last;
    } census_item_t;

    logic clk;
    logic rst_n;

    sct_pixel_if pix_if ();
    sct_desc_if  desc_if ();
    sct_cfg_if   cfg_if ();

    sparse_census_transform i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pix_if),
        .desc_out (desc_if),
        .cfg_wr   (cfg_if)
    );

    // predictor state
    logic [PIX_W-1:0] line_mem [LINE_ROWS*MAX_WIDTH_DEF];
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    cfg_t             regs;

    census_item_t expected_descs[$];

    int  errors = 0;
    int  checked = 0;
    int  pixels_sent;
    int  cycles = 0;
    bit  idle_en;
    int  hold_len;
    int  hold_req_cnt = 0;
    int  hold_ack_cnt = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d descriptors outstanding", $time,
                     expected_descs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int offset_of(logic [3:0] nib, int rad);
        int v;
        v = nib[3] ? int'(nib) - 16 : int'(nib);
        if (v > rad)
        begin
            v = rad;
        end
        if (v < -rad)
        begin
            v = -rad;
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] line_at(int unsigned r, int unsigned c);
        return line_mem[(r % LINE_ROWS) * MAX_WIDTH_DEF + (c % MAX_WIDTH_DEF)];
    endfunction

    // advance the raster model by one pixel; queue a descriptor if interior
    task automatic predict_census(logic [PIX_W-1:0] pix, logic fs);
        int unsigned  w, h, rad, cnt, r, c, cr, cc;
        int           dy, dx;
        logic [7:0]   smp;
        logic [63:0]  half;
        census_item_t exp_item;
        w   = 32'(regs.image_width);
        h   = 32'(regs.image_height);
        rad = 32'(regs.window_radius);
        cnt = 32'(regs.sample_count);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h == 0) h = 1;
        if (h > 4096) h = 4096;
        if (rad > MAX_RADIUS_DEF) rad = MAX_RADIUS_DEF;
        if (cnt > MAX_SAMPLES_DEF) cnt = MAX_SAMPLES_DEF;
        if (fs)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
        begin
            row_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        line_mem[(r % LINE_ROWS) * MAX_WIDTH_DEF + c] = pix;
        if (r >= 2 * rad && c >= 2 * rad)
        begin
            cr = r - rad;
            cc = c - rad;
            exp_item.descriptor = '0;
            for (int k = 0; k < cnt; k++)
            begin
                half = (k < 8) ? regs.pattern_first_half : regs.pattern_second_half;
                smp  = half[8*(k%8) +: 8];
                dy   = offset_of(smp[7:4], rad);
                dx   = offset_of(smp[3:0], rad);
                if (line_at(int'(cr) + dy, int'(cc) + dx) >= line_at(cr, cc))
                begin
                    exp_item.descriptor[k] = 1'b1;
                end
            end
            exp_item.center_row = cr[ROW_W-1:0];
            exp_item.center_col = cc[COL_W-1:0];
            exp_item.frame_last = (r == h - 1 && c == w - 1);
            expected_descs.push_back(exp_item);
        end
        col_cnt = c + 1;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h)
            begin
                row_cnt = 0;
            end
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            pix_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        pix_if.valid       = 1'b1;
        pix_if.pixel_value = pix;
        pix_if.frame_start = fs;
        do
        begin
            @(posedge clk);
        end
        while (!pix_if.ready);
        predict_census(pix, fs);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic stop_pixels();
        pix_if.valid = 1'b0;
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
        cfg_if.valid     = 1'b1;
        cfg_if.reg_index = idx;
        cfg_if.reg_data  = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        case (idx)
            REG_IMAGE_WIDTH:    regs.image_width         = data[11:0];
            REG_IMAGE_HEIGHT:   regs.image_height        = data[12:0];
            REG_WINDOW_RADIUS:  regs.window_radius       = data[2:0];
            REG_SAMPLE_COUNT:   regs.sample_count        = data[4:0];
            REG_PATTERN_FIRST:  regs.pattern_first_half  = data;
            REG_PATTERN_SECOND: regs.pattern_second_half = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // wait until every queued descriptor is out, then let trailing pixels settle
    task automatic wait_drained();
        stop_pixels();
        while (expected_descs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_geometry(int w, int h, int rad, int cnt,
                                logic [63:0] pat0, logic [63:0] pat1);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 64'(w));
        write_reg(REG_IMAGE_HEIGHT, 64'(h));
        write_reg(REG_WINDOW_RADIUS, 64'(rad));
        write_reg(REG_SAMPLE_COUNT, 64'(cnt));
        write_reg(REG_PATTERN_FIRST, pat0);
        write_reg(REG_PATTERN_SECOND, pat1);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return PIX_W'($urandom_range(0, 3));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] rand_pattern();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_frames(int npix, bit first_fs);
        for (int i = 0; i < npix; i++)
        begin
            send_pixel(rand_pixel(), first_fs && i == 0);
        end
    endtask

    // output side: random stalls, long hold on request, checks on accept
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            desc_if.ready = 1'b0;
        end
        else if (hold_ack_cnt != hold_req_cnt)
        begin
            hold_ack_cnt  = hold_req_cnt;
            hold_left     = hold_len - 1;
            desc_if.ready = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            desc_if.ready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            desc_if.ready = 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left    = $urandom_range(0, 5);
            desc_if.ready = 1'b0;
        end
        else
        begin
            desc_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        census_item_t exp_item;
        if (rst_n && desc_if.valid && desc_if.ready)
        begin
            if (expected_descs.size() == 0)
            begin
                $display("%0t: unexpected descriptor %h row %0d col %0d", $time,
                         desc_if.descriptor, desc_if.center_row, desc_if.center_col);
                errors++;
            end
            else
            begin
                exp_item = expected_descs.pop_front();
                checked++;
                if (desc_if.descriptor !== exp_item.descriptor)
                begin
                    $display("%0t: descriptor expected %h actual %h", $time,
                             exp_item.descriptor, desc_if.descriptor);
                    errors++;
                end
                if (desc_if.center_row !== exp_item.center_row)
                begin
                    $display("%0t: center_row expected %0d actual %0d", $time,
                             exp_item.center_row, desc_if.center_row);
                    errors++;
                end
                if (desc_if.center_col !== exp_item.center_col)
                begin
                    $display("%0t: center_col expected %0d actual %0d", $time,
                             exp_item.center_col, desc_if.center_col);
                    errors++;
                end
                if (desc_if.frame_last !== exp_item.frame_last)
                begin
                    $display("%0t: frame_last expected %b actual %b", $time,
                             exp_item.frame_last, desc_if.frame_last);
                    errors++;
                end
            end
        end
    end

    // default height, radius, count and zero pattern on a narrow image:
    // every descriptor bit is set
    task automatic test_reset_defaults();
        write_reg(REG_IMAGE_WIDTH, 64'd8);
        send_frames(8 * 6, 1'b1);
    endtask

    task automatic test_extremes();
        // zero width and height act as a 1x1 frame
        set_geometry(0, 0, 0, 16, 64'h0, 64'h0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h80, 1'b1);
        // oversized width clamps; radius 0 over a two row frame
        set_geometry(12'hfff, 2, 0, 16, 64'h0f1f_f1ff_01f0_1011,
                     64'h0110_ff00_f00f_1f0f);
        send_frames(MAX_WIDTH_DEF + 2, 1'b1);
        // max radius, offsets beyond it, oversized sample count
        set_geometry(16, 16, 7, 31, 64'h8877_7887_0880_7008,
                     64'h9a3c_c3a9_5e6d_d6e5);
        send_frames(16 * 16, 1'b1);
        // no samples: zero descriptor; oversized height
        set_geometry(4, 13'h1fff, 0, 0, 64'hffff_ffff_ffff_ffff,
                     64'hffff_ffff_ffff_ffff);
        send_frames(20, 1'b1);
    endtask

    // frames run back to back with no frame_start after the first; counters wrap
    task automatic test_frame_wrap();
        set_geometry(6, 5, 1, 8, rand_pattern(), rand_pattern());
        send_frames(6 * 5 * 2 + 7, 1'b1);
    endtask

    // width shrunk mid-frame; a column past the new width would move to a new row
    task automatic test_midframe_shrink();
        set_geometry(12, 10, 1, 16, rand_pattern(), rand_pattern());
        send_frames(40, 1'b1);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 64'd5);
        send_frames(60, 1'b0);
    endtask

    task automatic test_backpressure();
        set_geometry(8, 6, 0, 16, rand_pattern(), rand_pattern());
        hold_len = 300;
        hold_req_cnt++;
        send_frames(50, 1'b1);
        wait_drained();
        send_frames(30, 1'b1);
    endtask

    task automatic test_random(int budget);
        int sent;
        int w, h, npix;
        sent = 0;
        while (sent < budget)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                            : $urandom_range(1, 20);
            h = $urandom_range(1, 16);
            set_geometry(w, h, $urandom_range(0, 7), $urandom_range(0, 20),
                         rand_pattern(), rand_pattern());
            npix = w * h * $urandom_range(1, 2);
            if (npix > 120)
            begin
                npix = 120;
            end
            for (int i = 0; i < npix; i++)
            begin
                // mostly clean frames, with an odd restart mid-frame
                send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 60) == 0);
            end
            sent += npix;
        end
    endtask

    initial
    begin
        pixels_sent = 0;
        idle_en     = 1'b1;
        hold_len    = 0;
        row_cnt     = 0;
        col_cnt     = 0;
        regs        = '{image_width: 640, image_height: 480, window_radius: 2,
                        sample_count: 16, pattern_first_half: 0,
                        pattern_second_half: 0};
        for (int i = 0; i < LINE_ROWS * MAX_WIDTH_DEF; i++)
        begin
            line_mem[i] = '0;
        end
        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        pix_if.frame_start = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.reg_index   = REG_IMAGE_WIDTH;
        cfg_if.reg_data    = '0;
        rst_n              = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_extremes();
        test_frame_wrap();
        test_midframe_shrink();
        test_backpressure();
        test_random(240);
        idle_en = 1'b0;
        test_random(120);
        wait_drained();

        $display("Sent %0d pixels, checked %0d descriptors over directed and random",
                 pixels_sent, checked);
        $display("geometries, radii 0-7, sample counts 0-31, stalls and a long hold.");
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sct_pkg.sv
hw/rtl/sct_ifs.sv
hw/rtl/sct_ram.sv
hw/rtl/sct_fifo.sv
hw/rtl/sct_front.sv
hw/rtl/sct_back.sv
hw/rtl/sparse_census_transform.sv
test/tb_top.sv
